>>> hw/rtl/mma_pkg.sv
// ============================================================================
// mma_pkg
// Shared types and constants for the multichannel moving average block:
// action codes, controller states and the controller/datapath handshake.
// ============================================================================
`default_nettype none

package mma_pkg;

    localparam int          SAMPLE_W           = 12;
    localparam logic [15:0] SAMPLE_MASK        = 16'h0FFF;
    localparam logic [31:0] DEFAULT_SESSION_MS = 32'd60000;

    typedef enum logic [1:0] {
        ACT_START  = 2'd0,
        ACT_SAMPLE = 2'd1,
        ACT_POLL   = 2'd2
    } action_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_READ,
        ST_ADD,
        ST_DIV,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic latch_in;
        logic exec;
        logic rd_issue;
        logic acc_add;
        logic div_step;
        logic load_out;
    } ctl_cmd_t;

    typedef struct packed {
        logic take_sample;
        logic rd_last;
        logic div_last;
    } ctl_stat_t;

endpackage

`default_nettype wire

>>> hw/rtl/mma_ctrl.sv
// ============================================================================
// mma_ctrl
// Sequencer for one transaction: execute the action; for a stored sample,
// sweep the channel window, run the divider; then load the output register.
// ============================================================================
`default_nettype none

module mma_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output mma_pkg::ctl_cmd_t         cmd,
    input  wire mma_pkg::ctl_stat_t   stat
);

    mma_pkg::state_t state_reg;
    mma_pkg::state_t state_next;
    logic            out_valid_reg;
    logic            out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mma_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            mma_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.latch_in = 1'b1;
                    state_next   = mma_pkg::ST_EXEC;
                end
            end
            mma_pkg::ST_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = stat.take_sample ? mma_pkg::ST_READ : mma_pkg::ST_OUT;
            end
            mma_pkg::ST_READ:
            begin
                cmd.rd_issue = 1'b1;
                state_next   = mma_pkg::ST_ADD;
            end
            mma_pkg::ST_ADD:
            begin
                cmd.acc_add = 1'b1;
                state_next  = stat.rd_last ? mma_pkg::ST_DIV : mma_pkg::ST_READ;
            end
            mma_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    state_next = mma_pkg::ST_OUT;
                end
            end
            mma_pkg::ST_OUT:
            begin
                // hold the result until the output register frees up
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = mma_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mma_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

>>> hw/rtl/mma_datapath.sv
// ============================================================================
// mma_datapath
// Session timing, round-robin channel pointer, sample memory, window
// accumulator, restoring divider and the output register.
// ============================================================================
`default_nettype none

module mma_datapath #(
    parameter int NUM_CHANNELS = 16,
    parameter int WINDOW_DEPTH = 4
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire mma_pkg::ctl_cmd_t    cmd,
    output mma_pkg::ctl_stat_t        stat,
    input  wire logic                 cfg_wr_en,
    input  wire logic [31:0]          cfg_wr_data,
    input  wire logic [1:0]           action,
    input  wire logic [15:0]          raw_word,
    input  wire logic [31:0]          time_now,
    output logic                      accepted,
    output logic [3:0]                channel,
    output logic [11:0]               average,
    output logic [2:0]                window_fill,
    output logic                      cycle_done,
    output logic [31:0]               timestamp,
    output logic                      complete
);

    localparam int CH_W      = $clog2(NUM_CHANNELS);
    localparam int SLOT_W    = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int FILL_W    = $clog2(WINDOW_DEPTH + 1);
    localparam int CMP_W     = FILL_W + 1;
    localparam int SUM_W     = mma_pkg::SAMPLE_W + $clog2(WINDOW_DEPTH);
    localparam int DCNT_W    = $clog2(SUM_W);
    localparam int ADDR_W    = CH_W + SLOT_W;
    localparam int MEM_DEPTH = 2 ** ADDR_W;

    // latched transaction
    logic [1:0]                   act_reg;
    logic [mma_pkg::SAMPLE_W-1:0] sample_reg;
    logic [31:0]                  now_reg;

    // session and round-robin state
    logic [31:0]       session_len_reg;
    logic [31:0]       start_time_reg;
    logic              done_reg;
    logic [31:0]       cyc_ts_reg;
    logic [CH_W-1:0]   chan_idx_reg;
    logic [SLOT_W-1:0] round_slot_reg;
    logic [FILL_W-1:0] round_fill_reg;

    // per-transaction working registers
    logic [CH_W-1:0]              cur_ch_reg;
    logic [FILL_W-1:0]            cur_fill_reg;
    logic [SLOT_W-1:0]            rd_slot_reg;
    logic [mma_pkg::SAMPLE_W-1:0] rd_data_reg;
    logic [SUM_W-1:0]             acc_reg;
    logic [FILL_W-1:0]            rem_reg;
    logic [DCNT_W-1:0]            div_cnt_reg;
    logic                         res_acc_reg;
    logic                         res_wrap_reg;

    // output register
    logic        accepted_reg;
    logic [3:0]  channel_reg;
    logic [11:0] average_reg;
    logic [2:0]  window_fill_reg;
    logic        cycle_done_reg;
    logic [31:0] timestamp_reg;
    logic        complete_reg;

    logic [mma_pkg::SAMPLE_W-1:0] mem [MEM_DEPTH];

    logic [15:0]       masked_word;
    logic [31:0]       elapsed;
    logic              expired;
    logic              take_sample;
    logic              chan_last;
    logic              slot_last;
    logic              round_full;
    logic [FILL_W-1:0] fill_next;
    logic [FILL_W:0]   div_shift;
    logic [FILL_W:0]   div_trial;
    logic              div_ge;

    assign masked_word = raw_word & mma_pkg::SAMPLE_MASK;
    assign elapsed     = now_reg - start_time_reg;
    assign expired     = (elapsed >= session_len_reg);
    assign take_sample = (act_reg == mma_pkg::ACT_SAMPLE) && !done_reg;
    assign chan_last   = (chan_idx_reg == CH_W'(NUM_CHANNELS - 1));
    assign slot_last   = (round_slot_reg == SLOT_W'(WINDOW_DEPTH - 1));
    assign round_full  = (round_fill_reg == FILL_W'(WINDOW_DEPTH));
    assign fill_next   = round_full ? round_fill_reg : round_fill_reg + FILL_W'(1);

    // one bit of restoring division per step
    assign div_shift = {rem_reg, acc_reg[SUM_W-1]};
    assign div_trial = div_shift - {1'b0, cur_fill_reg};
    assign div_ge    = !div_trial[FILL_W];

    assign stat.take_sample = take_sample;
    assign stat.rd_last     = (CMP_W'(rd_slot_reg) + CMP_W'(1)) == CMP_W'(cur_fill_reg);
    assign stat.div_last    = (div_cnt_reg == DCNT_W'(SUM_W - 1));

    // Each channel has seen either the same number of samples as the completed
    // rounds or one more, so one round counter stands in for per-channel
    // fill and slot pointers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            session_len_reg <= mma_pkg::DEFAULT_SESSION_MS;
            start_time_reg  <= '0;
            done_reg        <= 1'b0;
            cyc_ts_reg      <= '0;
            chan_idx_reg    <= '0;
            round_slot_reg  <= '0;
            round_fill_reg  <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                session_len_reg <= cfg_wr_data;
            end
            if (cmd.exec)
            begin
                unique case (act_reg)
                    mma_pkg::ACT_START:
                    begin
                        done_reg       <= 1'b0;
                        start_time_reg <= now_reg;
                    end
                    mma_pkg::ACT_SAMPLE:
                    begin
                        if (!done_reg)
                        begin
                            done_reg <= expired;
                            if (chan_last)
                            begin
                                chan_idx_reg   <= '0;
                                cyc_ts_reg     <= elapsed;
                                round_slot_reg <= slot_last ? '0
                                                            : round_slot_reg + SLOT_W'(1);
                                round_fill_reg <= fill_next;
                            end
                            else
                            begin
                                chan_idx_reg <= chan_idx_reg + CH_W'(1);
                            end
                        end
                    end
                    mma_pkg::ACT_POLL:
                    begin
                        if (expired)
                        begin
                            done_reg <= 1'b1;
                        end
                    end
                    default:
                    begin
                        done_reg <= done_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec && take_sample)
        begin
            mem[{chan_idx_reg, round_slot_reg}] <= sample_reg;
        end
        if (cmd.rd_issue)
        begin
            rd_data_reg <= mem[{cur_ch_reg, rd_slot_reg}];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            act_reg    <= action;
            sample_reg <= masked_word[mma_pkg::SAMPLE_W-1:0];
            now_reg    <= time_now;
        end
        if (cmd.exec)
        begin
            cur_ch_reg   <= chan_idx_reg;
            cur_fill_reg <= fill_next;
            res_acc_reg  <= take_sample;
            res_wrap_reg <= take_sample && chan_last;
            rd_slot_reg  <= '0;
            acc_reg      <= '0;
            rem_reg      <= '0;
            div_cnt_reg  <= '0;
        end
        else if (cmd.acc_add)
        begin
            acc_reg     <= acc_reg + SUM_W'(rd_data_reg);
            rd_slot_reg <= rd_slot_reg + SLOT_W'(1);
        end
        else if (cmd.div_step)
        begin
            rem_reg     <= div_ge ? div_trial[FILL_W-1:0] : div_shift[FILL_W-1:0];
            acc_reg     <= {acc_reg[SUM_W-2:0], div_ge};
            div_cnt_reg <= div_cnt_reg + DCNT_W'(1);
        end
        if (cmd.load_out)
        begin
            accepted_reg    <= res_acc_reg;
            channel_reg     <= res_acc_reg ? 4'(cur_ch_reg) : 4'd0;
            average_reg     <= res_acc_reg ? acc_reg[11:0] : 12'd0;
            window_fill_reg <= res_acc_reg ? 3'(cur_fill_reg) : 3'd0;
            cycle_done_reg  <= res_wrap_reg;
            timestamp_reg   <= cyc_ts_reg;
            complete_reg    <= done_reg;
        end
    end

    assign accepted    = accepted_reg;
    assign channel     = channel_reg;
    assign average     = average_reg;
    assign window_fill = window_fill_reg;
    assign cycle_done  = cycle_done_reg;
    assign timestamp   = timestamp_reg;
    assign complete    = complete_reg;

`ifndef SYNTH
    a_round_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        round_fill_reg <= FILL_W'(WINDOW_DEPTH))
        else $error("round fill beyond window depth");

    a_chan_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        (CH_W + 1)'(chan_idx_reg) < (CH_W + 1)'(NUM_CHANNELS))
        else $error("channel index out of range");

    a_sweep_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.acc_add |-> (CMP_W'(rd_slot_reg) < CMP_W'(cur_fill_reg)))
        else $error("window sweep past held samples");

    a_div_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> (rem_reg < cur_fill_reg))
        else $error("divider remainder not below divisor");

    a_sample_advances: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.exec && take_sample) |=> (chan_idx_reg != $past(chan_idx_reg)))
        else $error("stored sample did not advance channel");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/multichannel_moving_average.sv
// ============================================================================
// multichannel_moving_average
// Round-robin multichannel moving average with session timing.
// ============================================================================
`default_nettype none

// Converter words arrive for channels in strict round-robin order; each stored
// sample goes into its channel's window and the transaction returns the
// truncated window mean, with elapsed session time recorded at every wrap of
// the channel index. One transaction is in flight at a time. A start, poll,
// ignored or unused action passes only through the execute and output
// states; a stored sample also sweeps the samples held for its channel
// through the single read port of the sample memory, with a read and an add
// per held sample, and then runs the divider, which produces one quotient bit
// per cycle. The output register lets the next transaction be accepted while
// a result still waits to be taken.

module multichannel_moving_average #(
    parameter int NUM_CHANNELS = 16,
    parameter int WINDOW_DEPTH = 4
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [31:0] cfg_wr_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  action,
    input  wire logic [15:0] raw_word,
    input  wire logic [31:0] time_now,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             accepted,
    output logic [3:0]       channel,
    output logic [11:0]      average,
    output logic [2:0]       window_fill,
    output logic             cycle_done,
    output logic [31:0]      timestamp,
    output logic             complete
);

    mma_pkg::ctl_cmd_t  cmd;
    mma_pkg::ctl_stat_t stat;

    mma_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    mma_datapath #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .action      (action),
        .raw_word    (raw_word),
        .time_now    (time_now),
        .accepted    (accepted),
        .channel     (channel),
        .average     (average),
        .window_fill (window_fill),
        .cycle_done  (cycle_done),
        .timestamp   (timestamp),
        .complete    (complete)
    );

endmodule

`default_nettype wire
